FILE: rtl/core/htc_pkg.sv
// Shared types and constants for the host traffic counter table.
package htc_pkg;

	localparam int HTC_ENTRIES = 256;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam int ETH_HDR_BYTES = 14;
	localparam int IPV4_HDR_BYTES = 20;
	localparam logic [15:0] MIN_FRAME_BYTES = 16'(ETH_HDR_BYTES + IPV4_HDR_BYTES);

	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_NOT_IPV4 = 3'd0,
		ST_SHORT    = 3'd1,
		ST_UPDATED  = 3'd2,
		ST_CREATED  = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

	typedef struct packed {
		logic        lookup;
		status_t     rej_status;
		logic        egress;
		logic [31:0] key;
		logic [31:0] other;
		logic [15:0] tlen;
	} item_t;

	typedef struct packed {
		logic [31:0] inner_addr;
		logic [31:0] in_bytes;
		logic [31:0] in_pkts;
		logic [31:0] out_bytes;
		logic [31:0] out_pkts;
	} rec_t;

endpackage

FILE: rtl/core/htc_front.sv
// Front end: classifies packet metadata and queues it for the table engine.
module htc_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	output logic           busy,
	input  logic           op,
	input  logic [15:0]    ether_type,
	input  logic [15:0]    frame_length,
	input  logic [31:0]    source_addr,
	input  logic [31:0]    dest_addr,
	input  logic [15:0]    ip_total_length,
	output logic           q_valid,
	output htc_pkg::item_t q_item,
	input  logic           q_pop
);
	import htc_pkg::*;

	item_t               q_mem [Q_DEPTH];
	item_t               new_item;
	logic [Q_PTR_W-1:0]  wr_ptr_q;
	logic [Q_PTR_W-1:0]  rd_ptr_q;
	logic [Q_CNT_W-1:0]  count_q;
	logic                push;

	always_comb begin
		new_item            = '0;
		new_item.egress     = op;
		new_item.key        = op ? dest_addr : source_addr;
		new_item.other      = op ? source_addr : dest_addr;
		new_item.tlen       = ip_total_length;
		priority if (ether_type != ETHERTYPE_IPV4) begin
			new_item.lookup     = 1'b0;
			new_item.rej_status = ST_NOT_IPV4;
		end else if (frame_length < MIN_FRAME_BYTES) begin
			new_item.lookup     = 1'b0;
			new_item.rej_status = ST_SHORT;
		end else begin
			new_item.lookup     = 1'b1;
			new_item.rej_status = ST_UPDATED;
		end
	end

	assign busy    = (count_q == Q_CNT_W'(Q_DEPTH));
	assign push    = start && !busy;
	assign q_valid = (count_q != '0);
	assign q_item  = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= new_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= Q_PTR_W'(wr_ptr_q + 1'b1);
			end
			if (q_pop) begin
				rd_ptr_q <= Q_PTR_W'(rd_ptr_q + 1'b1);
			end
			if (push && !q_pop) begin
				count_q <= Q_CNT_W'(count_q + 1'b1);
			end else if (!push && q_pop) begin
				count_q <= Q_CNT_W'(count_q - 1'b1);
			end
		end
	end

endmodule

FILE: rtl/core/htc_back.sv
// Back end: scans the key table, updates or creates entries and drives results.
module htc_back #(
	parameter int ENTRIES = htc_pkg::HTC_ENTRIES
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           q_valid,
	input  htc_pkg::item_t q_item,
	output logic           q_pop,
	output logic           done,
	output logic [2:0]     status,
	output logic [7:0]     entry_index,
	output logic [31:0]    inside_addr,
	output logic [31:0]    in_bytes,
	output logic [31:0]    in_packets,
	output logic [31:0]    out_bytes,
	output logic [31:0]    out_packets
);
	import htc_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_READ,
		S_UPDATE
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   used_q;
	logic [CNT_W-1:0]   scan_q;
	logic               cmp_vld_q;
	logic [IDX_W-1:0]   cmp_idx_q;
	logic [IDX_W-1:0]   slot_q;
	item_t              cur_q;

	logic [31:0]        key_mem [ENTRIES];
	rec_t               rec_mem [ENTRIES];
	logic [31:0]        key_rd_q;
	rec_t               rec_rd_q;

	logic               scan_issue;
	logic               hit;
	logic               miss;
	logic               full;
	logic               create;
	rec_t               new_rec;
	rec_t               upd_rec;
	logic               rec_we;
	logic [IDX_W-1:0]   rec_waddr;
	rec_t               rec_wdata;
	logic [IDX_W-1:0]   used_idx;

	logic               emit_en;
	status_t            emit_status;
	logic               emit_show;
	logic [IDX_W-1:0]   emit_slot;
	rec_t               emit_rec;
	logic [IDX_W+7:0]   slot_ext;

	assign used_idx   = used_q[IDX_W-1:0];
	assign q_pop      = (state_q == S_IDLE) && q_valid;
	assign scan_issue = (state_q == S_SCAN) && (scan_q < used_q);
	assign hit        = (state_q == S_SCAN) && cmp_vld_q && (key_rd_q == cur_q.key);
	assign miss       = (state_q == S_SCAN) && !cmp_vld_q && !(scan_q < used_q);
	assign full       = (used_q == CNT_W'(ENTRIES));
	assign create     = miss && !full;

	always_comb begin
		new_rec            = '0;
		new_rec.inner_addr = cur_q.other;
		if (cur_q.egress) begin
			new_rec.out_bytes = {16'd0, cur_q.tlen};
			new_rec.out_pkts  = 32'd1;
		end else begin
			new_rec.in_bytes  = {16'd0, cur_q.tlen};
			new_rec.in_pkts   = 32'd1;
		end

		upd_rec            = rec_rd_q;
		upd_rec.inner_addr = cur_q.other;
		if (cur_q.egress) begin
			upd_rec.out_bytes = rec_rd_q.out_bytes + {16'd0, cur_q.tlen};
			upd_rec.out_pkts  = rec_rd_q.out_pkts + 32'd1;
		end else begin
			upd_rec.in_bytes  = rec_rd_q.in_bytes + {16'd0, cur_q.tlen};
			upd_rec.in_pkts   = rec_rd_q.in_pkts + 32'd1;
		end

		rec_we    = create || (state_q == S_UPDATE);
		rec_waddr = create ? used_idx : slot_q;
		rec_wdata = create ? new_rec : upd_rec;
	end

	always_comb begin
		emit_en     = 1'b0;
		emit_status = ST_NOT_IPV4;
		emit_show   = 1'b0;
		emit_slot   = slot_q;
		emit_rec    = upd_rec;
		unique case (state_q)
			S_IDLE: begin
				if (q_valid && !q_item.lookup) begin
					emit_en     = 1'b1;
					emit_status = q_item.rej_status;
				end
			end
			S_SCAN: begin
				if (create) begin
					emit_en     = 1'b1;
					emit_status = ST_CREATED;
					emit_show   = 1'b1;
					emit_slot   = used_idx;
					emit_rec    = new_rec;
				end else if (miss) begin
					emit_en     = 1'b1;
					emit_status = ST_FULL;
				end
			end
			S_READ: begin
				emit_en = 1'b0;
			end
			S_UPDATE: begin
				emit_en     = 1'b1;
				emit_status = ST_UPDATED;
				emit_show   = 1'b1;
			end
			default: begin
				emit_en = 1'b0;
			end
		endcase
	end

	assign slot_ext = {8'd0, emit_slot};

	always_ff @(posedge clk) begin
		if (create) begin
			key_mem[used_idx] <= cur_q.key;
		end
		key_rd_q <= key_mem[scan_q[IDX_W-1:0]];
	end

	always_ff @(posedge clk) begin
		if (rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		rec_rd_q <= rec_mem[slot_q];
	end

	always_ff @(posedge clk) begin
		cmp_idx_q <= scan_q[IDX_W-1:0];
		if (q_pop) begin
			cur_q <= q_item;
		end
		if (hit) begin
			slot_q <= cmp_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			used_q      <= '0;
			scan_q      <= '0;
			cmp_vld_q   <= 1'b0;
			done        <= 1'b0;
			status      <= '0;
			entry_index <= '0;
			inside_addr <= '0;
			in_bytes    <= '0;
			in_packets  <= '0;
			out_bytes   <= '0;
			out_packets <= '0;
		end else begin
			cmp_vld_q <= scan_issue && !hit;
			done      <= emit_en;
			if (emit_en) begin
				status      <= emit_status;
				entry_index <= emit_show ? slot_ext[7:0] : 8'd0;
				inside_addr <= emit_show ? emit_rec.inner_addr : 32'd0;
				in_bytes    <= emit_show ? emit_rec.in_bytes : 32'd0;
				in_packets  <= emit_show ? emit_rec.in_pkts : 32'd0;
				out_bytes   <= emit_show ? emit_rec.out_bytes : 32'd0;
				out_packets <= emit_show ? emit_rec.out_pkts : 32'd0;
			end
			unique case (state_q)
				S_IDLE: begin
					scan_q <= '0;
					if (q_valid && q_item.lookup) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (scan_issue) begin
						scan_q <= CNT_W'(scan_q + 1'b1);
					end
					if (hit) begin
						state_q <= S_READ;
					end else if (miss) begin
						state_q <= S_IDLE;
						if (!full) begin
							used_q <= CNT_W'(used_q + 1'b1);
						end
					end
				end
				S_READ: begin
					state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/core/host_traffic_counter_table.sv
// Top level of the per-host traffic counter table.
//
// An item (one packet's metadata) is transferred at a rising edge where start is
// high and busy is low. Busy rises only when the two-entry front queue is full.
// Each item gives exactly one result, shown for one cycle with done high; the
// receiver cannot stall, so results leave in the order the items arrived.
// Items that are not IPv4 or are too short skip the table: the back end answers
// them as soon as it takes them from the queue. A lookup reads one stored key per
// cycle from the key memory, so a miss (creation or table full) is answered once
// every valid entry has been compared, with no scan in an empty table, and a hit
// at slot K once slots 0 to K are compared and the record at K is read and
// updated. That key memory scan sets the throughput.
// Entries are allocated in order and never freed, so the fill count alone
// marks which slots are valid. Reset empties the queue and the table at once,
// with no clearing pass; the contents of the memories are then meaningless
// until written.
module host_traffic_counter_table #(
	parameter int ENTRIES = htc_pkg::HTC_ENTRIES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [15:0] ether_type,
	input  logic [15:0] frame_length,
	input  logic [31:0] source_addr,
	input  logic [31:0] dest_addr,
	input  logic [15:0] ip_total_length,
	output logic        done,
	output logic [2:0]  status,
	output logic [7:0]  entry_index,
	output logic [31:0] inside_addr,
	output logic [31:0] in_bytes,
	output logic [31:0] in_packets,
	output logic [31:0] out_bytes,
	output logic [31:0] out_packets
);
	import htc_pkg::*;

	logic  q_valid;
	logic  q_pop;
	item_t q_item;

	htc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.op              (op),
		.ether_type      (ether_type),
		.frame_length    (frame_length),
		.source_addr     (source_addr),
		.dest_addr       (dest_addr),
		.ip_total_length (ip_total_length),
		.q_valid         (q_valid),
		.q_item          (q_item),
		.q_pop           (q_pop)
	);

	htc_back #(
		.ENTRIES (ENTRIES)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.done        (done),
		.status      (status),
		.entry_index (entry_index),
		.inside_addr (inside_addr),
		.in_bytes    (in_bytes),
		.in_packets  (in_packets),
		.out_bytes   (out_bytes),
		.out_packets (out_packets)
	);

endmodule

FILE: rtl/core/htc_checker.sv
// Port-level checks for the host traffic counter table, bound to the top level.
module htc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  status,
	input logic [7:0]  entry_index,
	input logic [31:0] inside_addr,
	input logic [31:0] in_bytes,
	input logic [31:0] in_packets,
	input logic [31:0] out_bytes,
	input logic [31:0] out_packets
);
	import htc_pkg::*;

	// A result that records nothing carries no table contents.
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_NOT_IPV4 || status == ST_SHORT || status == ST_FULL)
		|-> entry_index == 8'd0 && inside_addr == 32'd0 && in_bytes == 32'd0 &&
		    in_packets == 32'd0 && out_bytes == 32'd0 && out_packets == 32'd0)
		else $error("non-recording result carries table contents");

	// A newly created entry has counted exactly one packet in one direction.
	a_created_one: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_CREATED
		|-> (in_packets == 32'd1 && out_packets == 32'd0 && out_bytes == 32'd0) ||
		    (in_packets == 32'd0 && out_packets == 32'd1 && in_bytes == 32'd0))
		else $error("created entry does not hold a single packet");

	// The queue can only fill up after a transfer.
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && !busy))
		else $error("busy rose without a preceding transfer");

endmodule

bind host_traffic_counter_table htc_checker u_htc_checker (.*);

FILE: test/tb.sv
// Self-checking testbench for the host traffic counter table.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import htc_pkg::*;

	localparam int TABLE_SLOTS = HTC_ENTRIES;
	localparam int STALL_LIMIT = 4000;
	localparam int END_DRAIN_CYCLES = 300;

	typedef struct packed {
		logic        op;
		logic [15:0] etype;
		logic [15:0] flen;
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] tlen;
	} packet_t;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] inner_addr;
		logic [31:0] in_bytes;
		logic [31:0] in_pkts;
		logic [31:0] out_bytes;
		logic [31:0] out_pkts;
	} host_rec_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  index;
		logic [31:0] inner_addr;
		logic [31:0] in_bytes;
		logic [31:0] in_pkts;
		logic [31:0] out_bytes;
		logic [31:0] out_pkts;
	} tally_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        op = 1'b0;
	logic [15:0] ether_type = '0;
	logic [15:0] frame_length = '0;
	logic [31:0] source_addr = '0;
	logic [31:0] dest_addr = '0;
	logic [15:0] ip_total_length = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [7:0]  entry_index;
	logic [31:0] inside_addr;
	logic [31:0] in_bytes;
	logic [31:0] in_packets;
	logic [31:0] out_bytes;
	logic [31:0] out_packets;

	packet_t     pending[$];
	tally_t      tally_q[$];
	logic [31:0] key_pool[$];
	host_rec_t   hosts[TABLE_SLOTS];
	int          hosts_used = 0;
	int          sent_count = 0;
	int          taken_count = 0;
	int          errors = 0;
	int          gap_pct = 0;
	int          quiet_cycles = 0;
	logic        took_item = 1'b0;

	host_traffic_counter_table #(.ENTRIES(TABLE_SLOTS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.op(op),
		.ether_type(ether_type),
		.frame_length(frame_length),
		.source_addr(source_addr),
		.dest_addr(dest_addr),
		.ip_total_length(ip_total_length),
		.done(done),
		.status(status),
		.entry_index(entry_index),
		.inside_addr(inside_addr),
		.in_bytes(in_bytes),
		.in_packets(in_packets),
		.out_bytes(out_bytes),
		.out_packets(out_packets)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic tally_t account_packet(input logic egress, input logic [15:0] etype,
			input logic [15:0] flen, input logic [31:0] src, input logic [31:0] dst,
			input logic [15:0] tlen);
		tally_t      t;
		logic [31:0] key;
		logic [31:0] other;
		int          slot;
		int          i;
		t = '0;
		if (etype != ETHERTYPE_IPV4) begin
			t.status = ST_NOT_IPV4;
			return t;
		end
		if (flen < MIN_FRAME_BYTES) begin
			t.status = ST_SHORT;
			return t;
		end
		key = egress ? dst : src;
		other = egress ? src : dst;
		slot = -1;
		for (i = 0; i < hosts_used; i++) begin
			if (slot < 0 && hosts[i].key == key)
				slot = i;
		end
		if (slot >= 0) begin
			hosts[slot].inner_addr = other;
			if (egress) begin
				hosts[slot].out_bytes += tlen;
				hosts[slot].out_pkts += 1;
			end else begin
				hosts[slot].in_bytes += tlen;
				hosts[slot].in_pkts += 1;
			end
			t.status = ST_UPDATED;
		end else if (hosts_used == TABLE_SLOTS) begin
			t.status = ST_FULL;
			return t;
		end else begin
			slot = hosts_used;
			hosts_used++;
			hosts[slot].key = key;
			hosts[slot].inner_addr = other;
			hosts[slot].in_bytes = egress ? 32'd0 : 32'(tlen);
			hosts[slot].in_pkts = egress ? 32'd0 : 32'd1;
			hosts[slot].out_bytes = egress ? 32'(tlen) : 32'd0;
			hosts[slot].out_pkts = egress ? 32'd1 : 32'd0;
			t.status = ST_CREATED;
		end
		t.index = 8'(slot);
		t.inner_addr = hosts[slot].inner_addr;
		t.in_bytes = hosts[slot].in_bytes;
		t.in_pkts = hosts[slot].in_pkts;
		t.out_bytes = hosts[slot].out_bytes;
		t.out_pkts = hosts[slot].out_pkts;
		return t;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		$display("%0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
	endtask

	always @(negedge clk) begin : drive
		packet_t nxt;
		if (arst_n && (!start || took_item)) begin
			if (pending.size() != 0 && $urandom_range(99) >= gap_pct) begin
				nxt = pending.pop_front();
				start <= 1'b1;
				op <= nxt.op;
				ether_type <= nxt.etype;
				frame_length <= nxt.flen;
				source_addr <= nxt.src;
				dest_addr <= nxt.dst;
				ip_total_length <= nxt.tlen;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : watch
		tally_t want;
		if (!arst_n) begin
			took_item <= 1'b0;
		end else begin
			took_item <= start && !busy;
			if (done) begin
				if (tally_q.size() == 0) begin
					report_mismatch("result transfer with no packet outstanding");
				end else begin
					want = tally_q.pop_front();
					check_field("status", 32'(status), 32'(want.status));
					check_field("entry_index", 32'(entry_index), 32'(want.index));
					check_field("inside_addr", inside_addr, want.inner_addr);
					check_field("in_bytes", in_bytes, want.in_bytes);
					check_field("in_packets", in_packets, want.in_pkts);
					check_field("out_bytes", out_bytes, want.out_bytes);
					check_field("out_packets", out_packets, want.out_pkts);
				end
			end
			if (start && !busy) begin
				tally_q.push_back(account_packet(op, ether_type, frame_length, source_addr,
					dest_addr, ip_total_length));
				taken_count++;
			end
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic queue_packet(input logic dir, input logic [15:0] etype,
			input logic [15:0] flen, input logic [31:0] src, input logic [31:0] dst,
			input logic [15:0] tlen);
		pending.push_back('{dir, etype, flen, src, dst, tlen});
		sent_count++;
	endtask

	// Mostly well-formed IPv4 packets keyed from a pool of known hosts, with
	// fresh hosts mixed in so that the table eventually fills up.
	task automatic queue_random_packet();
		packet_t     p;
		int          roll;
		logic [31:0] key;
		roll = $urandom_range(99);
		p.op = 1'($urandom_range(1));
		p.etype = ETHERTYPE_IPV4;
		p.flen = 16'($urandom_range(65535, MIN_FRAME_BYTES));
		p.src = $urandom;
		p.dst = $urandom;
		p.tlen = 16'($urandom);
		if (roll < 8) begin
			p.etype = 16'($urandom);
			p.flen = 16'($urandom);
		end else if (roll < 14) begin
			p.flen = 16'($urandom_range(MIN_FRAME_BYTES - 1, 0));
		end else begin
			if (roll < 74 && key_pool.size() != 0) begin
				key = key_pool[$urandom_range(key_pool.size() - 1)];
			end else begin
				key = $urandom;
				key_pool.push_back(key);
			end
			if (p.op)
				p.dst = key;
			else
				p.src = key;
		end
		queue_packet(p.op, p.etype, p.flen, p.src, p.dst, p.tlen);
	endtask

	// Holds the sender back until every transfer has been made and answered.
	task automatic settle();
		while (taken_count != sent_count || tally_q.size() != 0)
			@(negedge clk);
		@(posedge clk);
	endtask

	initial begin : stimulus
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		queue_packet(1'b0, 16'h0000, 16'd64, 32'h0A000001, 32'hC0A80001, 16'd60);
		queue_packet(1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 16'hFFFF);
		queue_packet(1'b0, 16'h0801, 16'd64, 32'h0A000001, 32'hC0A80001, 16'd60);
		queue_packet(1'b0, 16'h86DD, 16'd0, 32'h0A000001, 32'hC0A80001, 16'd60);
		queue_packet(1'b0, ETHERTYPE_IPV4, 16'd0, 32'h0A000001, 32'hC0A80001, 16'd60);
		queue_packet(1'b1, ETHERTYPE_IPV4, MIN_FRAME_BYTES - 16'd1, 32'h0A000001,
			32'hC0A80001, 16'd60);
		queue_packet(1'b0, ETHERTYPE_IPV4, MIN_FRAME_BYTES, 32'h0A000001, 32'hC0A80001,
			16'd0);
		queue_packet(1'b0, ETHERTYPE_IPV4, 16'hFFFF, 32'h0A000001, 32'hC0A80002, 16'hFFFF);
		queue_packet(1'b1, ETHERTYPE_IPV4, 16'd1500, 32'hC0A80003, 32'h0A000001, 16'd100);
		queue_packet(1'b1, ETHERTYPE_IPV4, 16'd1500, 32'hC0A80003, 32'h08080808, 16'hFFFF);
		queue_packet(1'b0, ETHERTYPE_IPV4, 16'd60, 32'h00000000, 32'hFFFFFFFF, 16'd40);
		queue_packet(1'b1, ETHERTYPE_IPV4, 16'd60, 32'h00000000, 32'hFFFFFFFF, 16'd40);
		queue_packet(1'b0, ETHERTYPE_IPV4, 16'd60, 32'hFFFFFFFF, 32'h00000000, 16'd1);
		queue_packet(1'b1, ETHERTYPE_IPV4, 16'd60, 32'hFFFFFFFF, 32'h00000000, 16'hFFFF);
		queue_packet(1'b0, ETHERTYPE_IPV4, 16'd60, 32'h08080808, 32'h0A000001, 16'd20);
		queue_packet(1'b1, ETHERTYPE_IPV4, 16'd60, 32'h0A000001, 32'h0A000001, 16'd20);
		key_pool.push_back(32'h0A000001);
		key_pool.push_back(32'h08080808);
		key_pool.push_back(32'h00000000);
		key_pool.push_back(32'hFFFFFFFF);
		settle();

		gap_pct = 0;
		repeat (434) queue_random_packet();
		settle();
		gap_pct = 79;
		repeat (434) queue_random_packet();
		settle();
		gap_pct = 13;
		repeat (434) queue_random_packet();
		settle();
		gap_pct = 0;
		repeat (434) queue_random_packet();
		settle();

		repeat (END_DRAIN_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/core/htc_pkg.sv
rtl/core/htc_front.sv
rtl/core/htc_back.sv
rtl/core/host_traffic_counter_table.sv
rtl/core/htc_checker.sv
test/tb.sv
